// ===== rtl/gemm_pkg.sv =====
// package: shared constants, types and a helper function for the matrix multiply block
package gemm_pkg;

  localparam int unsigned MaxDimDefault = 16;

  localparam int unsigned ElemW  = 16;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned DimW   = 5;
  localparam int unsigned AccW   = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // request codes
  localparam logic [ReqW-1:0] ReqWrA  = 3'd0;
  localparam logic [ReqW-1:0] ReqWrB  = 3'd1;
  localparam logic [ReqW-1:0] ReqWrC  = 3'd2;
  localparam logic [ReqW-1:0] ReqRun  = 3'd3;
  localparam logic [ReqW-1:0] ReqRdC  = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTransA = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTransB = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRowsM  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegColsN  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInnerK = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAlpha  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBeta   = 3'd6;

  // result kinds
  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [IdxW-1:0]  row_index;
    logic [IdxW-1:0]  col_index;
    logic signed [ElemW-1:0] elem_value;
  } req_word_t;

  typedef struct packed {
    logic             result_kind;
    logic [IdxW-1:0]  out_row;
    logic [IdxW-1:0]  out_col;
    logic signed [ElemW-1:0] out_value;
    logic             saturated;
  } rsp_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic acc_clear;   // start a new dot product
    logic acc_add;     // add product from last fetch
    logic fin_start;   // capture dot and prior c, begin scaling
    logic sat_clear;
  } dp_cmd_t;

  // round half up of a Q34.24 sum to Q8.8 and saturate
  function automatic logic [ElemW:0] round_sat(input logic signed [57:0] total);
    logic signed [57:0] r;
    logic signed [41:0] q;
    logic [ElemW:0] res;
    r = total + 58'sd32768;
    q = r[57:16];
    if (q > 42'sd32767) res = {1'b1, 16'h7fff};
    else if (q < -42'sd32768) res = {1'b1, 16'h8000};
    else res = {1'b0, q[ElemW-1:0]};
    return res;
  endfunction

endpackage

// ===== rtl/gemm_stream_if.sv =====
// interface: valid/ready channel carrying one payload word
interface gemm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gemm_ram.sv =====
// generic single-port-write, single-read ram with registered read
module gemm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/gemm_datapath.sv =====
// datapath: a, b, c stores, multiply-accumulate, alpha/beta scaling and rounding
module gemm_datapath import gemm_pkg::*; #(
  parameter int unsigned MaxDim = MaxDimDefault,
  localparam int unsigned AW = $clog2(MaxDim * MaxDim)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  input  logic                     a_we_i,
  input  logic                     b_we_i,
  input  logic                     c_we_ext_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic signed [ElemW-1:0]  wdata_i,
  input  logic [AW-1:0]            a_raddr_i,
  input  logic [AW-1:0]            b_raddr_i,
  input  logic [AW-1:0]            c_raddr_i,
  input  logic [AW-1:0]            c_wb_addr_i,
  input  logic                     c_wb_i,
  input  logic signed [ElemW-1:0]  alpha_i,
  input  logic signed [ElemW-1:0]  beta_i,
  output logic signed [ElemW-1:0]  c_rdata_o,
  output logic                     fin_done_o,
  output logic                     sat_o
);
  logic signed [ElemW-1:0] a_rd, b_rd;
  logic signed [2*ElemW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic [1:0] add_q;
  logic signed [AccW+ElemW-1:0] alpha_prod_q;
  logic signed [2*ElemW-1:0] beta_prod_q;
  logic [1:0] fin_q;
  logic signed [ElemW-1:0] res_q;
  logic res_sat_q;
  logic sat_q;
  logic c_we;
  logic [AW-1:0] c_waddr;
  logic signed [ElemW-1:0] c_wdata;
  logic signed [57:0] total;
  logic [ElemW:0] rs;

  gemm_ram #(.Width(ElemW), .Depth(MaxDim*MaxDim)) u_a (
    .clk_i, .we_i(a_we_i), .waddr_i, .wdata_i, .raddr_i(a_raddr_i), .rdata_o(a_rd));
  gemm_ram #(.Width(ElemW), .Depth(MaxDim*MaxDim)) u_b (
    .clk_i, .we_i(b_we_i), .waddr_i, .wdata_i, .raddr_i(b_raddr_i), .rdata_o(b_rd));

  // c store written by requests or by the writeback of a result
  assign c_we    = c_we_ext_i | c_wb_i;
  assign c_waddr = c_wb_i ? c_wb_addr_i : waddr_i;
  assign c_wdata = c_wb_i ? res_q : wdata_i;
  gemm_ram #(.Width(ElemW), .Depth(MaxDim*MaxDim)) u_c (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr_i), .rdata_o(c_rdata_o));

  // product stage then accumulate, add flag follows ram read and product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q <= '0;
      acc_q <= '0;
    end else begin
      add_q <= {add_q[0], cmd_i.acc_add};
      if (cmd_i.acc_clear) acc_q <= '0;
      else if (add_q[1]) acc_q <= acc_q + AccW'(prod_q);
    end
  end
  always_ff @(posedge clk_i) begin
    prod_q <= a_rd * b_rd;
  end

  // scaling: alpha*dot and beta*c, then round and saturate
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_start) begin
      alpha_prod_q <= alpha_i * acc_q;
      beta_prod_q  <= beta_i * c_rdata_o;
    end
    if (fin_q[0]) begin
      res_q     <= rs[ElemW-1:0];
      res_sat_q <= rs[ElemW];
    end
  end
  assign total = 58'(alpha_prod_q) + {{18{beta_prod_q[2*ElemW-1]}}, beta_prod_q, 8'd0};
  assign rs = round_sat(total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= '0;
      sat_q <= 1'b0;
    end else begin
      fin_q <= {fin_q[0], cmd_i.fin_start};
      if (cmd_i.sat_clear) sat_q <= 1'b0;
      else if (fin_q[1] && res_sat_q) sat_q <= 1'b1;
    end
  end

  assign fin_done_o = fin_q[1];
  assign sat_o = sat_q;
endmodule

// ===== rtl/gemm_ctrl.sv =====
// controller: request decode and the i, j, k loop sequencer
module gemm_ctrl import gemm_pkg::*; #(
  parameter int unsigned MaxDim = MaxDimDefault,
  localparam int unsigned AW = $clog2(MaxDim * MaxDim),
  localparam int unsigned LW = $clog2(MaxDim + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  gemm_stream_if.sink              req_if,
  gemm_stream_if.sink              cfg_if,
  gemm_stream_if.source            rsp_if,
  output dp_cmd_t                  cmd_o,
  output logic                     a_we_o,
  output logic                     b_we_o,
  output logic                     c_we_o,
  output logic [AW-1:0]            waddr_o,
  output logic signed [ElemW-1:0]  wdata_o,
  output logic [AW-1:0]            a_raddr_o,
  output logic [AW-1:0]            b_raddr_o,
  output logic [AW-1:0]            c_raddr_o,
  output logic [AW-1:0]            c_wb_addr_o,
  output logic                     c_wb_o,
  output logic signed [ElemW-1:0]  alpha_o,
  output logic signed [ElemW-1:0]  beta_o,
  input  logic signed [ElemW-1:0]  c_rdata_i,
  input  logic                     fin_done_i,
  input  logic                     sat_i
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRdWait = 3'd1;
  localparam logic [2:0] StMac  = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StWait = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0] state_q, state_d;
  logic trans_a_q, trans_b_q;
  logic [DimW-1:0] rows_q, cols_q, inner_q;
  logic signed [ElemW-1:0] alpha_q, beta_q;
  logic [LW-1:0] m_lim, n_lim, k_lim;
  logic [LW-1:0] i_q, j_q, k_q;
  logic [1:0] drain_q;
  logic rsp_valid_q;
  rsp_word_t rsp_q;
  logic [IdxW-1:0] rd_row_q, rd_col_q;
  logic rd_in_q;
  logic req_fire, rsp_free;
  logic addr_ok;
  logic [AW-1:0] req_addr;
  logic [LW-1:0] ai, ak, bk, bj;

  // clamp dimensions to the store size
  function automatic logic [LW-1:0] clamp(input logic [DimW-1:0] d);
    return (32'(d) > MaxDim) ? LW'(MaxDim) : LW'(d);
  endfunction
  assign m_lim = clamp(rows_q);
  assign n_lim = clamp(cols_q);
  assign k_lim = clamp(inner_q);

  // configuration registers
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_a_q <= 1'b0; trans_b_q <= 1'b0;
      rows_q <= DimW'(16); cols_q <= DimW'(16); inner_q <= DimW'(16);
      alpha_q <= 16'sd256; beta_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.index)
        RegTransA: trans_a_q <= cfg_if.data.data[0];
        RegTransB: trans_b_q <= cfg_if.data.data[0];
        RegRowsM:  rows_q  <= cfg_if.data.data[DimW-1:0];
        RegColsN:  cols_q  <= cfg_if.data.data[DimW-1:0];
        RegInnerK: inner_q <= cfg_if.data.data[DimW-1:0];
        RegAlpha:  alpha_q <= cfg_if.data.data;
        RegBeta:   beta_q  <= cfg_if.data.data;
        default: ;
      endcase
    end
  end
  assign alpha_o = alpha_q;
  assign beta_o  = beta_q;

  // request decode
  assign rsp_free = !rsp_valid_q || rsp_if.ready;
  assign req_if.ready = (state_q == StIdle) && rsp_free;
  assign req_fire = req_if.valid && req_if.ready;
  assign addr_ok = (32'(req_if.data.row_index) < MaxDim) && (32'(req_if.data.col_index) < MaxDim);
  assign req_addr = AW'(32'(req_if.data.row_index) * MaxDim + 32'(req_if.data.col_index));
  assign waddr_o = req_addr;
  assign wdata_o = req_if.data.elem_value;
  assign a_we_o = req_fire && addr_ok && req_if.data.req_type == ReqWrA;
  assign b_we_o = req_fire && addr_ok && req_if.data.req_type == ReqWrB;
  assign c_we_o = req_fire && addr_ok && req_if.data.req_type == ReqWrC;

  // operand addresses for the current i, j, k
  assign ai = trans_a_q ? k_q : i_q;
  assign ak = trans_a_q ? i_q : k_q;
  assign bk = trans_b_q ? j_q : k_q;
  assign bj = trans_b_q ? k_q : j_q;
  assign a_raddr_o = AW'(32'(ai) * MaxDim + 32'(ak));
  assign b_raddr_o = AW'(32'(bk) * MaxDim + 32'(bj));
  assign c_wb_addr_o = AW'(32'(i_q) * MaxDim + 32'(j_q));
  assign c_raddr_o = (state_q == StIdle) ? req_addr : c_wb_addr_o;
  assign c_wb_o = fin_done_i;

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.sat_clear = req_fire && req_if.data.req_type == ReqRun;
    cmd_o.acc_clear = cmd_o.sat_clear || (state_q == StWait && fin_done_i);
    cmd_o.acc_add   = (state_q == StMac);
    cmd_o.fin_start = (state_q == StFin);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_fire && req_if.data.req_type == ReqRun)
          state_d = (m_lim == '0 || n_lim == '0) ? StOut : (k_lim == '0 ? StDrain : StMac);
        else if (req_fire && req_if.data.req_type == ReqRdC) state_d = StRdWait;
      end
      StRdWait: state_d = StIdle;
      StMac:   if (k_q == k_lim - 1'b1) state_d = StDrain;
      StDrain: if (drain_q == 2'd2) state_d = StFin;
      StFin:   state_d = StWait;
      StWait: begin
        if (fin_done_i) begin
          if (j_q == n_lim - 1'b1 && i_q == m_lim - 1'b1) state_d = StOut;
          else state_d = (k_lim == '0) ? StDrain : StMac;
        end
      end
      StOut:   if (rsp_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q <= '0; j_q <= '0; k_q <= '0; drain_q <= '0;
      rsp_valid_q <= 1'b0;
      rd_in_q <= 1'b0; rd_row_q <= '0; rd_col_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle) begin
        i_q <= '0; j_q <= '0; k_q <= '0; drain_q <= '0;
      end
      if (state_q == StMac) k_q <= k_q + 1'b1;
      if (state_q == StDrain) drain_q <= drain_q + 1'b1;
      if (state_q == StWait && fin_done_i) begin
        k_q <= '0; drain_q <= '0;
        if (j_q == n_lim - 1'b1) begin
          j_q <= '0; i_q <= i_q + 1'b1;
        end else j_q <= j_q + 1'b1;
      end
      if (req_fire) begin
        rd_in_q <= addr_ok;
        rd_row_q <= req_if.data.row_index;
        rd_col_q <= req_if.data.col_index;
      end
      // response register
      if (state_q == StRdWait) begin
        rsp_valid_q <= 1'b1;
        rsp_q.result_kind <= KindRead;
        rsp_q.out_row <= rd_row_q;
        rsp_q.out_col <= rd_col_q;
        rsp_q.out_value <= rd_in_q ? c_rdata_i : '0;
        rsp_q.saturated <= sat_i;
      end else if (state_q == StOut && rsp_free) begin
        rsp_valid_q <= 1'b1;
        rsp_q.result_kind <= KindDone;
        rsp_q.out_row <= '0;
        rsp_q.out_col <= '0;
        rsp_q.out_value <= '0;
        rsp_q.saturated <= sat_i;
      end else if (rsp_valid_q && rsp_if.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end
  assign rsp_if.valid = rsp_valid_q;
  assign rsp_if.data  = rsp_q;
endmodule

// ===== rtl/general_matrix_multiply_transpose_top.sv =====
// top level: matrix multiply with transpose, controller plus datapath
// element writes land in the store when the request is taken, a read returns through the c store and response registers
// a run computes the result elements one at a time on the single multiply-accumulate unit
// requests are held off while a run is in progress or a result waits
// rst_ni clears control, configuration and the saturation flag; stores are not cleared
module general_matrix_multiply_transpose_top import gemm_pkg::*; #(
  parameter int unsigned MaxDim = MaxDimDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gemm_stream_if.sink   req_if,
  gemm_stream_if.sink   cfg_if,
  gemm_stream_if.source rsp_if
);
  localparam int unsigned AW = $clog2(MaxDim * MaxDim);

  dp_cmd_t cmd;
  logic a_we, b_we, c_we, c_wb, fin_done, sat;
  logic [AW-1:0] waddr, a_ra, b_ra, c_ra, c_wba;
  logic signed [ElemW-1:0] wdata, alpha, beta, c_rd;

  gemm_ctrl #(.MaxDim(MaxDim)) u_ctrl (
    .clk_i, .rst_ni, .req_if, .cfg_if, .rsp_if, .cmd_o(cmd),
    .a_we_o(a_we), .b_we_o(b_we), .c_we_o(c_we), .waddr_o(waddr), .wdata_o(wdata),
    .a_raddr_o(a_ra), .b_raddr_o(b_ra), .c_raddr_o(c_ra), .c_wb_addr_o(c_wba),
    .c_wb_o(c_wb), .alpha_o(alpha), .beta_o(beta), .c_rdata_i(c_rd),
    .fin_done_i(fin_done), .sat_i(sat));

  gemm_datapath #(.MaxDim(MaxDim)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .a_we_i(a_we), .b_we_i(b_we), .c_we_ext_i(c_we),
    .waddr_i(waddr), .wdata_i(wdata), .a_raddr_i(a_ra), .b_raddr_i(b_ra),
    .c_raddr_i(c_ra), .c_wb_addr_i(c_wba), .c_wb_i(c_wb), .alpha_i(alpha),
    .beta_i(beta), .c_rdata_o(c_rd), .fin_done_o(fin_done), .sat_o(sat));
endmodule
